// ===== hw/rtl/art_pkg.sv =====
// ----------------------------------------------------------------------------
// art_pkg: shared types and constants of the address region table
// slot count, item kinds, status codes, controller states and the
// structs that run between the controller and the slot cells
// ----------------------------------------------------------------------------
package art_pkg;

	localparam int TABLE_SLOTS = 16;
	localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int DATA_W      = 64;

	typedef enum logic [1:0] {
		KIND_REG   = 2'd0,
		KIND_UNREG = 2'd1,
		KIND_LOOK  = 2'd2,
		KIND_TOTAL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_BAD    = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_UNUSED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_WALK = 2'd1,
		S_DONE = 2'd2
	} state_t;

	// item fields held steady by the controller while the token walks
	typedef struct packed {
		logic [DATA_W-1:0] id;
		logic [DATA_W-1:0] addr;
		logic [DATA_W-1:0] len;
	} art_cmd_t;

	// write broadcast from the controller into one slot
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic              set;
		logic [DATA_W-1:0] owner;
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] bytes;
	} art_wr_t;

	// partial result handed from cell to cell
	typedef struct packed {
		logic              active;
		logic              match_vld;
		logic [IDX_W-1:0]  match_idx;
		logic [DATA_W-1:0] match_bytes;
		logic              free_vld;
		logic [IDX_W-1:0]  free_idx;
		logic              hit_any;
		logic [DATA_W-1:0] found;
		logic [DATA_W-1:0] offset;
	} art_tok_t;

endpackage

// ===== hw/rtl/art_cell.sv =====
// ----------------------------------------------------------------------------
// art_cell: one slot of the region table
// holds one region and folds its own match, free and containment checks
// into the token passing by, one cell per cycle
// ----------------------------------------------------------------------------
module art_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [art_pkg::IDX_W-1:0] slot_idx,
	input  art_pkg::art_cmd_t       cmd,
	input  art_pkg::art_wr_t        wr,
	input  art_pkg::art_tok_t       tok_in,
	output art_pkg::art_tok_t       tok_out
);
	import art_pkg::*;

	logic              valid_q;
	logic [DATA_W-1:0] owner_q;
	logic [DATA_W-1:0] base_q;
	logic [DATA_W-1:0] bytes_q;
	logic              act_q;
	art_tok_t          tok_q;
	art_tok_t          tok_nxt;
	logic [DATA_W-1:0] diff;
	logic [DATA_W-1:0] span;
	logic              own_match;
	logic              own_hit;

	always_comb begin
		diff      = cmd.addr - base_q;
		span      = diff + cmd.len;
		own_match = valid_q && (owner_q == cmd.id);
		own_hit   = valid_q && (cmd.addr >= base_q) && (span <= bytes_q);
		tok_nxt   = tok_in;
		if (!tok_in.match_vld && own_match) begin
			tok_nxt.match_vld   = 1'b1;
			tok_nxt.match_idx   = slot_idx;
			tok_nxt.match_bytes = bytes_q;
		end
		if (!tok_in.free_vld && !valid_q) begin
			tok_nxt.free_vld = 1'b1;
			tok_nxt.free_idx = slot_idx;
		end
		// lowest owner id wins among containing regions
		if (own_hit && (!tok_in.hit_any || (owner_q < tok_in.found))) begin
			tok_nxt.hit_any = 1'b1;
			tok_nxt.found   = owner_q;
			tok_nxt.offset  = diff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			act_q   <= 1'b0;
		end else begin
			act_q <= tok_in.active;
			if (wr.en && (wr.idx == slot_idx)) begin
				valid_q <= wr.set;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.active) begin
			tok_q <= tok_nxt;
		end
		if (wr.en && wr.set && (wr.idx == slot_idx)) begin
			owner_q <= wr.owner;
			base_q  <= wr.base;
			bytes_q <= wr.bytes;
		end
	end

	always_comb begin
		tok_out        = tok_q;
		tok_out.active = act_q;
	end

endmodule

// ===== hw/rtl/address_region_table.sv =====
// ----------------------------------------------------------------------------
// address_region_table: table of owned memory regions with range lookup
// register, unregister, lookup and total-size items over a row of slot cells
// ----------------------------------------------------------------------------
// One item is taken at a time. In the cycle after it is accepted, a token
// enters the first slot cell and moves one cell per cycle down the row of
// TABLE_SLOTS cells, picking up the slot holding the same owner id, the
// lowest free slot and the containing region with the lowest id. When it
// leaves the last cell its result is registered and the controller, once
// the result register is free of a stalled result, writes the chosen slot,
// updates the running size total and loads the result register. The next
// item may be offered while a result still waits to be taken. Every result
// carries the running total and the quota.
// The quota register is written through cfg_valid/cfg_data, always ready.
// ----------------------------------------------------------------------------
module address_region_table (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] owner_id,
	input  logic [63:0] region_base,
	input  logic [63:0] region_bytes,
	input  logic [63:0] access_addr,
	input  logic [63:0] access_len,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] found_id,
	output logic [63:0] region_offset,
	output logic [63:0] sum_bytes,
	output logic [63:0] quota_out
);
	import art_pkg::*;

	// controller state
	state_t            state_q;
	state_t            state_nxt;
	logic              start_q;
	logic              accept;
	logic              out_free;
	logic              load_out;

	// held item
	kind_t             kind_q;
	art_cmd_t          cmd_q;
	logic [DATA_W-1:0] base_q;
	logic [DATA_W-1:0] bytes_q;

	// table bookkeeping
	logic [DATA_W-1:0] quota_q;
	logic [DATA_W-1:0] total_q;
	logic [DATA_W-1:0] total_nxt;
	logic [DATA_W-1:0] sub_bytes;
	logic [DATA_W-1:0] add_bytes;
	art_tok_t          fin_q;
	art_wr_t           wr;
	status_t           stat_nxt;

	// cell row
	art_tok_t          head_tok;
	art_tok_t          tok [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] tok_act;

	// result register
	logic              out_valid_q;
	status_t           status_q;
	logic [DATA_W-1:0] found_q;
	logic [DATA_W-1:0] offset_q;
	logic [DATA_W-1:0] sum_q;
	logic [DATA_W-1:0] quota_out_q;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// token enters the first cell once the item is held
	always_comb begin
		head_tok        = '0;
		head_tok.active = start_q;
	end

	for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
		if (g == 0) begin : g_head
			art_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.slot_idx (IDX_W'(g)),
				.cmd      (cmd_q),
				.wr       (wr),
				.tok_in   (head_tok),
				.tok_out  (tok[g])
			);
		end else begin : g_body
			art_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.slot_idx (IDX_W'(g)),
				.cmd      (cmd_q),
				.wr       (wr),
				.tok_in   (tok[g-1]),
				.tok_out  (tok[g])
			);
		end
		assign tok_act[g] = tok[g].active;
	end

	// next state, slot write and total upkeep
	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		load_out  = 1'b0;
		wr        = '0;
		wr.owner  = cmd_q.id;
		wr.base   = base_q;
		wr.bytes  = bytes_q;
		stat_nxt  = STAT_OK;
		sub_bytes = '0;
		add_bytes = '0;
		unique case (kind_q)
			KIND_REG: begin
				if (fin_q.match_vld) begin
					wr.idx    = fin_q.match_idx;
					wr.set    = 1'b1;
					sub_bytes = fin_q.match_bytes;
					add_bytes = bytes_q;
				end else if (fin_q.free_vld) begin
					wr.idx    = fin_q.free_idx;
					wr.set    = 1'b1;
					add_bytes = bytes_q;
				end else begin
					stat_nxt = STAT_FULL;
				end
			end
			KIND_UNREG: begin
				if (fin_q.match_vld) begin
					wr.idx    = fin_q.match_idx;
					wr.set    = 1'b0;
					sub_bytes = fin_q.match_bytes;
				end
			end
			KIND_LOOK: begin
				if (!fin_q.hit_any) begin
					stat_nxt = STAT_BAD;
				end
			end
			KIND_TOTAL: begin
			end
			default: begin
			end
		endcase
		total_nxt = total_q - sub_bytes + add_bytes;

		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nxt = S_WALK;
				end
			end
			S_WALK: begin
				if (tok_act[TABLE_SLOTS-1]) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					load_out  = 1'b1;
					// only a real change of a slot drives the write
					wr.en     = ((kind_q == KIND_REG) && (stat_nxt == STAT_OK)) ||
					            ((kind_q == KIND_UNREG) && fin_q.match_vld);
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			quota_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			start_q <= accept;
			if (cfg_valid && cfg_ready) begin
				quota_q <= cfg_data;
			end
			if (load_out) begin
				total_q     <= total_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= kind_t'(kind);
			cmd_q.id   <= owner_id;
			cmd_q.addr <= access_addr;
			cmd_q.len  <= access_len;
			base_q     <= region_base;
			bytes_q    <= region_bytes;
		end
		if (tok_act[TABLE_SLOTS-1]) begin
			fin_q <= tok[TABLE_SLOTS-1];
		end
		if (load_out) begin
			status_q    <= stat_nxt;
			found_q     <= ((kind_q == KIND_LOOK) && fin_q.hit_any) ? fin_q.found : '0;
			offset_q    <= ((kind_q == KIND_LOOK) && fin_q.hit_any) ? fin_q.offset : '0;
			sum_q       <= total_nxt;
			quota_out_q <= quota_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign found_id      = found_q;
	assign region_offset = offset_q;
	assign sum_bytes     = sum_q;
	assign quota_out     = quota_out_q;

	// at most one token in the cell row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_act))
		else $error("more than one token in the cell row");

	// no token walks while the controller is idle
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (tok_act == '0 && !start_q))
		else $error("token active while idle");

	// slots are written only when a result is loaded
	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == S_DONE && load_out))
		else $error("slot write outside the apply cycle");

	// an accepted item starts a walk
	a_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_WALK && start_q))
		else $error("accepted item did not start a walk");

	// token leaving the row ends the walk
	a_tail_done: assert property (@(posedge clk) disable iff (!arst_n)
		tok_act[TABLE_SLOTS-1] |=> (state_q == S_DONE))
		else $error("walk did not end after the last cell");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the address region table
// drives register, unregister, lookup and total items through the valid/stall
// ports with random gaps on both sides, predicts every answer from a local
// copy of the region table and checks each result field in arrival order
// ----------------------------------------------------------------------------
module tb_top;
	import art_pkg::*;

	localparam int          CLK_HALF     = 10;
	localparam int          ITEM_CYCLES  = TABLE_SLOTS + 3;
	localparam int          RAND_PHASES  = 6;
	localparam int          PHASE_ITEMS  = 300;
	localparam int          LIMIT_CYCLES = 1_000_000;
	localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

	// one input item as the block sees it
	typedef struct {
		kind_t       kind;
		logic [63:0] id;
		logic [63:0] base;
		logic [63:0] bytes;
		logic [63:0] addr;
		logic [63:0] len;
	} region_item_t;

	// one result item
	typedef struct {
		status_t     status;
		logic [63:0] found;
		logic [63:0] offset;
		logic [63:0] total;
		logic [63:0] quota;
	} region_res_t;

	// directed row: typed rows carry the answer written out by hand
	typedef struct {
		region_item_t item;
		bit           typed;
		region_res_t  res;
	} stim_row_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// every input starts at a known value
	logic        cfg_valid    = 1'b0;
	logic [63:0] cfg_data     = '0;
	logic        in_valid     = 1'b0;
	logic [1:0]  kind         = '0;
	logic [63:0] owner_id     = '0;
	logic [63:0] region_base  = '0;
	logic [63:0] region_bytes = '0;
	logic [63:0] access_addr  = '0;
	logic [63:0] access_len   = '0;
	logic        out_stall    = 1'b0;

	logic        cfg_ready;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  status;
	logic [63:0] found_id;
	logic [63:0] region_offset;
	logic [63:0] sum_bytes;
	logic [63:0] quota_out;

	// local copy of the region table, running total and quota
	bit          tbl_valid [TABLE_SLOTS] = '{default: 1'b0};
	logic [63:0] tbl_owner [TABLE_SLOTS];
	logic [63:0] tbl_base  [TABLE_SLOTS];
	logic [63:0] tbl_bytes [TABLE_SLOTS];
	logic [63:0] size_total = '0;
	logic [63:0] quota_reg  = '0;

	// answers still owed by the block, oldest first
	region_res_t answer_q [$];

	int mismatches = 0;
	int sent       = 0;
	int hit_seen   = 0;
	int miss_seen  = 0;
	int full_seen  = 0;
	int stall_hold = 0;
	bit no_idle    = 1'b0;

	always #(CLK_HALF) clk = ~clk;

	address_region_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.owner_id     (owner_id),
		.region_base  (region_base),
		.region_bytes (region_bytes),
		.access_addr  (access_addr),
		.access_len   (access_len),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.found_id     (found_id),
		.region_offset(region_offset),
		.sum_bytes    (sum_bytes),
		.quota_out    (quota_out)
	);

	// slot holding this owner, or -1
	function automatic int owner_slot(logic [63:0] id);
		for (int i = 0; i < TABLE_SLOTS; i++)
			if (tbl_valid[i] && tbl_owner[i] == id)
				return i;
		return -1;
	endfunction

	// apply one item to the local table and return the answer it earns
	function automatic region_res_t apply_region_item(region_item_t it);
		region_res_t r;
		int          slot;
		bit          any;
		logic [63:0] off;
		logic [63:0] reach;
		r.status = STAT_OK;
		r.found  = '0;
		r.offset = '0;
		any      = 1'b0;
		case (it.kind)
			KIND_REG: begin
				slot = owner_slot(it.id);
				if (slot < 0) begin
					// new owner takes the lowest free slot
					for (int i = 0; i < TABLE_SLOTS; i++)
						if (!tbl_valid[i] && slot < 0)
							slot = i;
					if (slot < 0) begin
						r.status = STAT_FULL;
						full_seen++;
					end
				end else begin
					// overwrite: old size leaves the total first
					size_total = size_total - tbl_bytes[slot];
				end
				if (slot >= 0) begin
					tbl_valid[slot] = 1'b1;
					tbl_owner[slot] = it.id;
					tbl_base[slot]  = it.base;
					tbl_bytes[slot] = it.bytes;
					size_total      = size_total + it.bytes;
				end
			end
			KIND_UNREG: begin
				slot = owner_slot(it.id);
				if (slot >= 0) begin
					size_total      = size_total - tbl_bytes[slot];
					tbl_valid[slot] = 1'b0;
				end
			end
			KIND_LOOK: begin
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					off   = it.addr - tbl_base[i];
					reach = off + it.len;  // wraps at 64 bits
					if (tbl_valid[i] && it.addr >= tbl_base[i] && reach <= tbl_bytes[i]) begin
						// lowest owner id wins among overlapping regions
						if (!any || tbl_owner[i] < r.found) begin
							r.found  = tbl_owner[i];
							r.offset = off;
							any      = 1'b1;
						end
					end
				end
				if (any)
					hit_seen++;
				else begin
					r.status = STAT_BAD;
					r.found  = '0;
					r.offset = '0;
					miss_seen++;
				end
			end
			default: ;
		endcase
		r.total = size_total;
		r.quota = quota_reg;
		return r;
	endfunction

	// 64-bit word with the extremes showing up often
	function automatic logic [63:0] rand_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return ALL_ONES;
		return {$urandom, $urandom};
	endfunction

	// uniform value in [0, top]
	function automatic logic [63:0] below(logic [63:0] top);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return (top == ALL_ONES) ? r : r % (top + 64'd1);
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic region_item_t random_region_item();
		region_item_t it;
		int           r;
		int           nvalid;
		int           pick;
		int           slot;
		logic [63:0]  off;
		// unused fields carry noise
		it.id    = rand_word();
		it.base  = rand_word();
		it.bytes = rand_word();
		it.addr  = rand_word();
		it.len   = rand_word();
		r = $urandom_range(0, 99);
		if (r < 30)
			it.kind = KIND_REG;
		else if (r < 45)
			it.kind = KIND_UNREG;
		else if (r < 90)
			it.kind = KIND_LOOK;
		else
			it.kind = KIND_TOTAL;
		// small id pool so overwrites, removals and a full table all happen
		if ($urandom_range(0, 9) != 0)
			it.id = 64'($urandom_range(0, 23));
		// bases cluster low or near the top, else anywhere
		r = $urandom_range(0, 9);
		if (r < 4)
			it.base = 64'($urandom_range(0, 65535));
		else if (r < 7)
			it.base = ALL_ONES - 64'($urandom_range(0, 65535));
		if ($urandom_range(0, 9) < 5)
			it.bytes = 64'($urandom_range(0, 4096));
		if (it.kind == KIND_LOOK) begin
			nvalid = 0;
			for (int i = 0; i < TABLE_SLOTS; i++)
				if (tbl_valid[i])
					nvalid++;
			if (nvalid > 0 && $urandom_range(0, 9) < 8) begin
				// aim at a live region: inside, exact fit or one byte past
				pick = $urandom_range(0, nvalid - 1);
				slot = 0;
				for (int i = 0; i < TABLE_SLOTS; i++)
					if (tbl_valid[i]) begin
						if (pick == 0)
							slot = i;
						pick--;
					end
				off = below(tbl_bytes[slot]);
				r   = $urandom_range(0, 9);
				if (r < 2)
					off = '0;
				it.addr = tbl_base[slot] + off;
				if (r == 2)
					it.len = tbl_bytes[slot] - off;
				else if (r == 3)
					it.len = tbl_bytes[slot] - off + 64'd1;
				else
					it.len = below(tbl_bytes[slot] - off);
			end else if ($urandom_range(0, 1) == 0) begin
				it.addr = 64'($urandom_range(0, 65535));
				it.len  = 64'($urandom_range(0, 256));
			end
		end
		return it;
	endfunction

	function automatic stim_row_t mk(kind_t k, logic [63:0] id, logic [63:0] base,
			logic [63:0] bytes, logic [63:0] addr, logic [63:0] len);
		stim_row_t row;
		row.item.kind  = k;
		row.item.id    = id;
		row.item.base  = base;
		row.item.bytes = bytes;
		row.item.addr  = addr;
		row.item.len   = len;
		row.typed      = 1'b0;
		row.res.status = STAT_OK;
		row.res.found  = '0;
		row.res.offset = '0;
		row.res.total  = '0;
		row.res.quota  = '0;
		return row;
	endfunction

	// directed rows run at the reset quota of zero
	function automatic stim_row_t mk_typed(stim_row_t row, status_t st, logic [63:0] found,
			logic [63:0] offset, logic [63:0] total);
		row.typed      = 1'b1;
		row.res.status = st;
		row.res.found  = found;
		row.res.offset = offset;
		row.res.total  = total;
		row.res.quota  = '0;
		return row;
	endfunction

	// offer one item after a random gap and record its answer once accepted
	task automatic send_row(stim_row_t row);
		int          gap;
		region_res_t r;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= row.item.kind;
		owner_id     <= row.item.id;
		region_base  <= row.item.base;
		region_bytes <= row.item.bytes;
		access_addr  <= row.item.addr;
		access_len   <= row.item.len;
		do @(posedge clk); while (in_stall);
		r = apply_region_item(row.item);
		answer_q.push_back(row.typed ? row.res : r);
		sent++;
	endtask

	// wait for every owed answer, then let the slot walk run dry
	task automatic settle();
		in_valid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (ITEM_CYCLES + 2) @(posedge clk);
	endtask

	task automatic write_quota(logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		quota_reg = value;
	endtask

	// result side: random stalls, each accepted result checked in order
	always @(posedge clk) begin
		region_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (answer_q.size() == 0) begin
				$error("result item with no answer pending");
				mismatches++;
			end else begin
				want = answer_q.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (found_id !== want.found) begin
					$error("found_id: expected %h, got %h", want.found, found_id);
					mismatches++;
				end
				if (region_offset !== want.offset) begin
					$error("region_offset: expected %h, got %h", want.offset, region_offset);
					mismatches++;
				end
				if (sum_bytes !== want.total) begin
					$error("sum_bytes: expected %h, got %h", want.total, sum_bytes);
					mismatches++;
				end
				if (quota_out !== want.quota) begin
					$error("quota_out: expected %h, got %h", want.quota, quota_out);
					mismatches++;
				end
			end
		end
		if (stall_hold > 0)
			stall_hold <= stall_hold - 1;
		else begin
			out_stall  <= !no_idle && ($urandom_range(0, 2) == 0);
			stall_hold <= pick_gap();
		end
	end

	initial begin
		stim_row_t   dir_rows [$];
		stim_row_t   row;
		logic [63:0] phase_quota [RAND_PHASES];
		int          n_dir;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table right after reset
		dir_rows.push_back(mk_typed(mk(KIND_TOTAL, 0, 0, 0, 0, 0), STAT_OK, 0, 0, 0));
		dir_rows.push_back(mk_typed(mk(KIND_LOOK, 0, 0, 0, 0, 0), STAT_BAD, 0, 0, 0));
		// unknown id on unregister changes nothing
		dir_rows.push_back(mk_typed(mk(KIND_UNREG, 5, 0, 0, 0, 0), STAT_OK, 0, 0, 0));
		// owner id zero registers, empty region still holds a zero-length access
		dir_rows.push_back(mk(KIND_REG, 0, 0, 0, ALL_ONES, ALL_ONES));
		dir_rows.push_back(mk_typed(mk(KIND_LOOK, ALL_ONES, ALL_ONES, ALL_ONES, 0, 0),
			STAT_OK, 0, 0, 0));
		// all-ones region, lookup whose end wraps past the top
		dir_rows.push_back(mk(KIND_REG, ALL_ONES, ALL_ONES, ALL_ONES, 0, 0));
		dir_rows.push_back(mk(KIND_LOOK, 0, 0, 0, ALL_ONES, 64'd2));
		// overlapping regions: the lower id wins
		dir_rows.push_back(mk(KIND_REG, 7, 64'h1000, 64'h100, 0, 0));
		dir_rows.push_back(mk(KIND_REG, 3, 64'h1080, 64'h100, 0, 0));
		dir_rows.push_back(mk(KIND_LOOK, 0, 0, 0, 64'h1090, 64'h10));
		// overwrite by same id swaps the size in the total
		dir_rows.push_back(mk(KIND_REG, 7, 64'h1000, 64'h200, 0, 0));
		dir_rows.push_back(mk_typed(mk(KIND_UNREG, ALL_ONES, 0, 0, 0, 0),
			STAT_OK, 0, 0, 64'h300));
		// fill the remaining slots with 16-byte regions
		for (int i = 0; i < 13; i++)
			dir_rows.push_back(mk(KIND_REG, 64'h100 + i, 64'h10000 + 16 * i, 64'h10,
				ALL_ONES, ALL_ONES));
		// table full, then an exact fit and one byte too long
		dir_rows.push_back(mk_typed(mk(KIND_REG, 64'h999, 0, 64'h55, 0, 0),
			STAT_FULL, 0, 0, 64'h3D0));
		dir_rows.push_back(mk(KIND_LOOK, 0, 0, 0, 64'h100C0, 64'h10));
		dir_rows.push_back(mk_typed(mk(KIND_LOOK, 0, 0, 0, 64'h100C0, 64'h11),
			STAT_BAD, 0, 0, 64'h3D0));

		foreach (dir_rows[i])
			send_row(dir_rows[i]);
		n_dir = sent;
		settle();

		// quota settings, extremes included; two phases run with no idling
		phase_quota[0] = ALL_ONES;
		phase_quota[1] = {$urandom, $urandom};
		phase_quota[2] = '0;
		phase_quota[3] = {$urandom, $urandom};
		phase_quota[4] = 64'd1;
		phase_quota[5] = {$urandom, $urandom};
		for (int p = 0; p < RAND_PHASES; p++) begin
			write_quota(phase_quota[p]);
			no_idle = (p == 2 || p == 5);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				row.item  = random_region_item();
				row.typed = 1'b0;
				send_row(row);
			end
			settle();
		end
		no_idle = 1'b0;

		$display("%0d items sent: %0d directed, the rest random over %0d quota settings",
			sent, n_dir, RAND_PHASES);
		$display("answers: %0d lookup hits, %0d lookup misses, %0d table-full registers",
			hit_seen, miss_seen, full_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("Mismatches found");
		$finish;
	end

endmodule
